[src/rre_pkg.sv]
// Shared constants, codes and types of the remapped Rice encoder.
`timescale 1ns / 1ps

package rre_pkg;

  localparam int unsigned TABLE_SETS  = 64;
  localparam int unsigned MAX_K       = 7;
  localparam int unsigned TIDX_W      = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam int unsigned REMAP_DEPTH = TABLE_SETS * 256;
  localparam int unsigned REMAP_AW    = $clog2(REMAP_DEPTH);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_REMAP = 2'd1,
    KIND_K     = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef struct packed {
    logic data;
    logic flush;
  } rre_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } rre_status_t;

endpackage

[src/rre_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module rre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/rre_packer.sv]
// Bit buffer, code placement and word output stage of the remapped Rice encoder.
`timescale 1ns / 1ps

module rre_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rre_pkg::rre_cmd_t   cmd_i,
  input  logic [7:0]          rank_i,
  input  logic [2:0]          k_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [31:0]         word_o,
  output logic                last_o,
  output rre_pkg::rre_status_t status_o
);

  import rre_pkg::*;

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_EMIT  = 2'd1;
  localparam logic [1:0] P_FLUSH = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [63:0] buf_q, buf_d;
  logic [6:0]  pending_q, pending_d;
  logic [9:0]  s_q, s_d;
  logic [7:0]  code_q, code_d;
  logic        valid_q, valid_d;
  logic [31:0] word_q, word_d;
  logic        last_q, last_d;

  logic [2:0]  k_eff;
  logic [7:0]  k_one;
  logic [8:0]  code_len;
  logic [7:0]  code_new;
  logic        out_free;

  assign k_eff    = (32'(k_i) > MAX_K) ? 3'(MAX_K) : k_i;
  assign k_one    = 8'd1 << k_eff;
  assign code_len = 9'd1 + 9'(k_eff) + 9'(rank_i >> k_eff);
  assign code_new = k_one | (rank_i & (k_one - 8'd1));
  assign out_free = !valid_q || ready_i;

  always_comb begin
    state_d   = state_q;
    buf_d     = buf_q;
    pending_d = pending_q;
    s_d       = s_q;
    code_d    = code_q;
    valid_d   = valid_q && !ready_i;
    word_d    = word_q;
    last_d    = last_q;
    case (state_q)
      P_IDLE: begin
        if (cmd_i.data) begin
          s_d     = 10'd64 - 10'(pending_q) - 10'(code_len);
          code_d  = code_new;
          state_d = P_EMIT;
        end else if (cmd_i.flush && (pending_q != 7'd0)) begin
          state_d = P_FLUSH;
        end
      end
      P_EMIT: begin
        if (s_q[9]) begin
          if (out_free) begin
            valid_d = 1'b1;
            word_d  = buf_q[63:32];
            last_d  = 1'b0;
            buf_d   = buf_q << 32;
            s_d     = s_q + 10'd32;
          end
        end else begin
          buf_d     = buf_q | (64'(code_q) << s_q[5:0]);
          pending_d = 7'd64 - 7'(s_q[5:0]);
          state_d   = P_IDLE;
        end
      end
      P_FLUSH: begin
        if (out_free) begin
          valid_d = 1'b1;
          word_d  = buf_q[63:32];
          if (pending_q > 7'd32) begin
            last_d    = 1'b0;
            buf_d     = buf_q << 32;
            pending_d = pending_q - 7'd32;
          end else begin
            last_d    = 1'b1;
            buf_d     = '0;
            pending_d = '0;
            state_d   = P_IDLE;
          end
        end
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= P_IDLE;
      buf_q     <= '0;
      pending_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      buf_q     <= buf_d;
      pending_q <= pending_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    code_q <= code_d;
    word_q <= word_d;
    last_q <= last_d;
  end

  assign valid_o        = valid_q;
  assign word_o         = word_q;
  assign last_o         = last_q;
  assign status_o.busy  = (state_q != P_IDLE);
  assign status_o.empty = (pending_q == 7'd0);

endmodule

[src/remapped_rice_encoder_unit.sv]
// Top level of the remapped Rice encoder: input decode, table memories and packer.
`timescale 1ns / 1ps

// Rice-codes a byte stream into 32-bit words, first coded bit in bit 31. The
// table set is zero_count >> 2; its remap and k entries live in two
// single-port memories with registered read data. A data byte goes through
// memory read, code length and code placement, and pushes from zero up to
// eight 32-bit words out of the 64-bit buffer; the single output register
// moves one word a cycle while the output side does not stall. An
// end-of-block item flushes up to two words, the last one marked by tlast.
// No new item is taken until the one before it is through. Entries that
// were never written read back as unknown data.
module remapped_rice_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,   // zero_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // symbol, table_split, rank, rice_k, zero fill
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // code_word
  output logic        m_axis_tlast
);

  import rre_pkg::*;

  logic [7:0]          zero_count_q;
  rre_cmd_t            cmd_q, cmd_d;
  rre_status_t         st;

  logic                accept;
  kind_e               kind;
  logic [7:0]          symbol;
  logic [5:0]          table_split;
  logic [7:0]          rank;
  logic [2:0]          rice_k;
  logic [15:0]         tsel_prod;
  logic [TIDX_W-1:0]   t_read;
  logic                split_ok;
  logic                remap_we;
  logic                k_we;
  logic [REMAP_AW-1:0] remap_addr;
  logic [TIDX_W-1:0]   k_addr;
  logic [2:0]          k_wdata;
  logic [7:0]          remap_rdata;
  logic [2:0]          k_rdata;

  assign kind        = kind_e'(s_axis_tuser);
  assign symbol      = s_axis_tdata[7:0];
  assign table_split = s_axis_tdata[13:8];
  assign rank        = s_axis_tdata[21:14];
  assign rice_k      = s_axis_tdata[24:22];

  assign s_axis_tready = !cmd_q.data && !cmd_q.flush && !st.busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tsel_prod = (16'(zero_count_q) * 16'(TABLE_SETS)) >> 8;
  assign t_read    = (32'(tsel_prod) >= TABLE_SETS) ? TIDX_W'(TABLE_SETS - 1)
                                                    : TIDX_W'(tsel_prod);
  assign split_ok  = (32'(table_split) < TABLE_SETS);

  assign remap_we   = accept && (kind == KIND_REMAP) && split_ok;
  assign k_we       = accept && (kind == KIND_K) && split_ok;
  assign remap_addr = remap_we ? REMAP_AW'({TIDX_W'(table_split), symbol})
                               : REMAP_AW'({t_read, symbol});
  assign k_addr     = k_we ? TIDX_W'(table_split) : t_read;
  assign k_wdata    = (32'(rice_k) > MAX_K) ? 3'(MAX_K) : rice_k;

  always_comb begin
    cmd_d.data  = accept && (kind == KIND_DATA);
    cmd_d.flush = accept && (kind == KIND_END);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_count_q <= '0;
      cmd_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        zero_count_q <= cfg_wdata_i;
      end
      cmd_q <= cmd_d;
    end
  end

  rre_ram #(
    .WIDTH (8),
    .DEPTH (REMAP_DEPTH)
  ) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (remap_we),
    .addr_i  (remap_addr),
    .wdata_i (rank),
    .rdata_o (remap_rdata)
  );

  rre_ram #(
    .WIDTH (3),
    .DEPTH (TABLE_SETS)
  ) u_k_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .addr_i  (k_addr),
    .wdata_i (k_wdata),
    .rdata_o (k_rdata)
  );

  rre_packer u_packer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_q),
    .rank_i   (remap_rdata),
    .k_i      (k_rdata),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .word_o   (m_axis_tdata),
    .last_o   (m_axis_tlast),
    .status_o (st)
  );

`ifndef ASSERT_OFF
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_q.data && cmd_q.flush))
    else $error("data and flush commands issued together");

  a_data_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == KIND_DATA)) |=> (cmd_q.data && !st.busy))
    else $error("accepted data byte did not reach the packer");

  a_empty_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q.flush && st.empty) |=> !st.busy)
    else $error("flush of an empty buffer started output");
`endif

endmodule
